[hw/rtl/plk_pkg.sv]
// plk_pkg: shared types and constants for the positional list block.
// Request and response payload structs, operation and status codes,
// the controller-to-datapath command group. No dependencies.
package plk_pkg;

   // Default sizing of the entry store
   localparam int DEPTH_DEFAULT      = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Reset value of the capacity register
   localparam logic [6:0] CAPACITY_RESET = 7'd40;

   // Operation codes carried in req mode
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_MODIFY = 2'd3;

   // Status codes carried in rsp status
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [1:0] STATUS_OUT_OF_END = 2'd3;

   // One request transfer
   typedef struct packed {
      logic [1:0]         mode;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_type;

   // One response transfer
   typedef struct packed {
      logic signed [31:0] read_value;
      logic [6:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // latch request, clamp position, decide status
      logic rd_pos;    // read entry at the clamped position
      logic shift_rd;  // read the neighbor that moves next
      logic shift_wr;  // write the moved entry and step the index
      logic finish;    // apply the final write and count, build response
   } cmd_type;

endpackage

[hw/rtl/positional_list_insert_remove.sv]
// positional_list_insert_remove: top level of the positional list block.
// Joins plk_controller and plk_datapath; depends on plk_pkg.
//
//  channel   ports                       direction  transfer when
//  request   start, busy, req_data       in         start && !busy
//  response  rsp_strobe, rsp_data        out        rsp_strobe (one cycle)
//  config    csr_we, csr_wdata           in         csr_we
//
// An insert or remove moves at most DEPTH-1 entries, and read and modify
// move none: each move is a read then a write through the entry memory,
// plus an index check. The response strobe comes in the cycle after the
// final step, and a new start is taken in that same cycle. Reset clears
// the count and loads the capacity register; the entry memory is not
// cleared. The receiver cannot stall responses.
module positional_list_insert_remove #(
   parameter int DEPTH      = plk_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = plk_pkg::VALUE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  plk_pkg::req_type req_data,
   output logic             rsp_strobe,
   output plk_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata
);

   plk_pkg::cmd_type cmd;
   logic             more;

   // Sequencer
   plk_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .more       (more),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Entry store and registers
   plk_datapath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .more      (more),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/plk_datapath.sv]
// plk_datapath: entry memory, count and capacity registers, index
// register and response register for the positional list.
// Depends on plk_pkg; driven by plk_controller commands.
module plk_datapath #(
   parameter int DEPTH      = plk_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = plk_pkg::VALUE_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  plk_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata,
   input  plk_pkg::cmd_type cmd,
   output logic             more,
   output plk_pkg::rsp_type rsp_data
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

   // Entry store
   logic [VALUE_BITS-1:0] mem [DEPTH];

   logic [CW-1:0]         count_ff, count_in;
   logic [6:0]            cap_ff;
   logic [1:0]            mode_ff;
   logic [1:0]            status_ff, status_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] rdata_ff;
   plk_pkg::rsp_type      rsp_ff, rsp_in;

   logic [CMPW-1:0]       cnt_c, posreq_c, cap_c, cap_eff, p_c, cnt_next_c;
   logic signed [63:0]    val_wide, rd_wide;
   logic signed [VALUE_BITS-1:0] rd_signed;
   logic                  ok;
   logic                  is_ins, is_rem;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data;

   assign cnt_c    = CMPW'(count_ff);
   assign posreq_c = CMPW'(req_data.position);
   assign cap_c    = CMPW'(cap_ff);
   assign cap_eff  = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
   assign val_wide = 64'(req_data.value);

   assign ok     = (status_ff == plk_pkg::STATUS_DONE);
   assign is_ins = (mode_ff == plk_pkg::MODE_INSERT);
   assign is_rem = (mode_ff == plk_pkg::MODE_REMOVE);

   // Clamp the position and decide the status from the incoming request
   always_comb begin
      status_in = plk_pkg::STATUS_DONE;
      p_c       = posreq_c;
      unique case (req_data.mode)
         plk_pkg::MODE_INSERT: begin
            if (cnt_c >= cap_eff || cnt_c >= DEPTH_C) begin
               status_in = plk_pkg::STATUS_FULL;
            end
            if (posreq_c > cnt_c) begin
               p_c = cnt_c;
            end
         end
         plk_pkg::MODE_READ: begin
            if (posreq_c >= cnt_c) begin
               status_in = plk_pkg::STATUS_OUT_OF_END;
            end
         end
         default: begin
            if (cnt_c == '0) begin
               status_in = plk_pkg::STATUS_EMPTY;
            end else if (posreq_c >= cnt_c) begin
               p_c = cnt_c - CMPW'(1);
            end
         end
      endcase
      pos_in = AW'(p_c);
   end

   // More entries left to move in the current shift
   always_comb begin
      more = 1'b0;
      if (ok) begin
         if (is_ins) begin
            more = (idx_ff > pos_ff);
         end else if (is_rem) begin
            more = ((CMPW'(idx_ff) + CMPW'(1)) < cnt_c);
         end
      end
   end

   // Index register: start point on load, step on each moved entry
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = (req_data.mode == plk_pkg::MODE_INSERT) ? AW'(cnt_c) : pos_in;
      end else if (cmd.shift_wr) begin
         idx_in = is_ins ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
      end
   end

   // Memory port selection
   always_comb begin
      rd_addr = pos_ff;
      if (cmd.shift_rd) begin
         rd_addr = is_ins ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
      end
      wr_en   = cmd.shift_wr ||
                (cmd.finish && ok && (is_ins || mode_ff == plk_pkg::MODE_MODIFY));
      wr_addr = cmd.shift_wr ? idx_ff : pos_ff;
      wr_data = cmd.shift_wr ? rdata_ff : val_ff;
   end

   // Count after the operation and the response word
   always_comb begin
      count_in = count_ff;
      if (cmd.finish && ok) begin
         if (is_ins) begin
            count_in = count_ff + CW'(1);
         end else if (is_rem) begin
            count_in = count_ff - CW'(1);
         end
      end
      cnt_next_c            = CMPW'(count_in);
      rd_signed             = rdata_ff;
      rd_wide               = 64'(rd_signed);
      rsp_in.read_value     = (ok && mode_ff == plk_pkg::MODE_READ) ? rd_wide[31:0] : 32'sd0;
      rsp_in.entry_count    = cnt_next_c[6:0];
      rsp_in.status         = status_ff;
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_pos || cmd.shift_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= plk_pkg::CAPACITY_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Request latch, index and response
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_data.mode;
         status_ff <= status_in;
         pos_ff    <= pos_in;
         val_ff    <= val_wide[VALUE_BITS-1:0];
      end
      idx_ff <= idx_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hw/rtl/plk_controller.sv]
// plk_controller: sequencer for one list operation at a time.
// Depends on plk_pkg; issues commands to plk_datapath.
module plk_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             more,
   output logic             busy,
   output logic             rsp_strobe,
   output plk_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   // Next state and registered outputs
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: state_in = more ? ST_SHIFT_RD : ST_FINISH;
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = ST_DISPATCH;
         ST_FINISH: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // Decode commands from the current state (and start, for load)
   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && start;
      cmd.rd_pos   = (state_ff == ST_DISPATCH);
      cmd.shift_rd = (state_ff == ST_SHIFT_RD);
      cmd.shift_wr = (state_ff == ST_SHIFT_WR);
      cmd.finish   = (state_ff == ST_FINISH);
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[verif/positional_list_insert_remove_tb.sv]
// positional_list_insert_remove_tb: self-checking bench for the positional list block.
// It predicts every response with its own list model, checks each strobed transfer,
// and drives directed and random operations. Depends on plk_pkg and the block's RTL.
module positional_list_insert_remove_tb;

   localparam int LIST_DEPTH   = plk_pkg::DEPTH_DEFAULT;
   localparam int LATENCY_MAX  = 3 + 3 * (LIST_DEPTH - 1);
   localparam int LIMIT_CYCLES = 1000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   plk_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   plk_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [6:0]       csr_wdata = '0;

   // List model: stored entries, entry count and capacity register
   logic [31:0]      list_entries [LIST_DEPTH];
   int               list_count = 0;
   int               list_capacity = int'(plk_pkg::CAPACITY_RESET);

   // Predicted responses in transfer order
   plk_pkg::rsp_type list_outcomes [$];

   int               mismatch_count = 0;
   int unsigned      cycle_count = 0;
   int               sender_idle_pct = 0;

   positional_list_insert_remove dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Apply one operation to the list model and return its response
   function automatic plk_pkg::rsp_type apply_list_op(input plk_pkg::req_type op);
      plk_pkg::rsp_type outcome;
      int               slot;
      int               room;
      outcome = '0;
      outcome.status = plk_pkg::STATUS_DONE;
      room = (list_capacity > LIST_DEPTH) ? LIST_DEPTH : list_capacity;
      slot = int'(op.position);
      case (op.mode)
         plk_pkg::MODE_INSERT: begin
            if (list_count >= room) begin
               outcome.status = plk_pkg::STATUS_FULL;
            end else begin
               // clamp to append, then open a hole at the slot
               if (slot > list_count) slot = list_count;
               for (int i = list_count; i > slot; i--) list_entries[i] = list_entries[i - 1];
               list_entries[slot] = op.value;
               list_count++;
            end
         end
         plk_pkg::MODE_REMOVE: begin
            if (list_count == 0) begin
               outcome.status = plk_pkg::STATUS_EMPTY;
            end else begin
               // clamp to the last entry, then close the gap
               if (slot >= list_count) slot = list_count - 1;
               for (int i = slot; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
               list_count--;
            end
         end
         plk_pkg::MODE_READ: begin
            if (slot >= list_count) begin
               outcome.status = plk_pkg::STATUS_OUT_OF_END;
            end else begin
               outcome.read_value = list_entries[slot];
            end
         end
         default: begin
            if (list_count == 0) begin
               outcome.status = plk_pkg::STATUS_EMPTY;
            end else begin
               if (slot >= list_count) slot = list_count - 1;
               list_entries[slot] = op.value;
            end
         end
      endcase
      outcome.entry_count = list_count[6:0];
      return outcome;
   endfunction

   // Check each response transfer against the oldest prediction
   always @(posedge clock) begin : check_rsp
      plk_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (list_outcomes.size() == 0) begin
            $display("%0t: unexpected response read_value %0d count %0d status %0d",
                     $time, rsp_data.read_value, rsp_data.entry_count, rsp_data.status);
            mismatch_count++;
         end else begin
            want = list_outcomes.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d actual %0d",
                        $time, want.read_value, rsp_data.read_value);
               mismatch_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_data.entry_count);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   // Send one operation; hold start until the block takes the transfer
   task automatic send_op(input logic [1:0] mode, input logic [5:0] pos,
                          input logic [31:0] val);
      plk_pkg::req_type op;
      op.mode = mode;
      op.position = pos;
      op.value = val;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      list_outcomes.push_back(apply_list_op(op));
   endtask

   // Stop sending and wait for every predicted response
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (list_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity register while the block is idle
   task automatic write_capacity(input int cap);
      wait_drained();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap[6:0];
      @(negedge clock);
      csr_we <= 1'b0;
      list_capacity = int'(cap[6:0]);
   endtask

   function automatic logic [5:0] pick_position();
      int last;
      last = (list_count > 0) ? list_count - 1 : 0;
      case ($urandom_range(7))
         0:       return 6'd0;
         1:       return last[5:0];
         2:       return list_count[5:0];
         3:       return 6'd63;
         4, 5:    return 6'($urandom_range(last));
         default: return 6'($urandom_range(63));
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Empty-list refusals, clamped positions, value extremes
   task automatic test_directed_ops();
      sender_idle_pct = 31;
      send_op(plk_pkg::MODE_READ,   6'd0,  32'h0);
      send_op(plk_pkg::MODE_REMOVE, 6'd5,  32'h0);
      send_op(plk_pkg::MODE_MODIFY, 6'd0,  32'h1111_1111);
      send_op(plk_pkg::MODE_INSERT, 6'd63, 32'h7fff_ffff);
      send_op(plk_pkg::MODE_INSERT, 6'd0,  32'h8000_0000);
      send_op(plk_pkg::MODE_INSERT, 6'd1,  32'hffff_ffff);
      send_op(plk_pkg::MODE_INSERT, 6'd63, 32'h0000_0000);
      send_op(plk_pkg::MODE_INSERT, 6'd2,  32'h5555_5555);
      send_op(plk_pkg::MODE_INSERT, 6'd0,  32'haaaa_aaaa);
      for (int p = 0; p < 6; p++) send_op(plk_pkg::MODE_READ, p[5:0], $urandom);
      send_op(plk_pkg::MODE_READ,   6'd6,  32'h0);
      send_op(plk_pkg::MODE_READ,   6'd63, 32'h0);
      send_op(plk_pkg::MODE_MODIFY, 6'd63, 32'h1234_5678);
      send_op(plk_pkg::MODE_MODIFY, 6'd0,  32'h0000_0001);
      send_op(plk_pkg::MODE_READ,   6'd5,  32'h0);
      send_op(plk_pkg::MODE_REMOVE, 6'd63, 32'h0);
      send_op(plk_pkg::MODE_REMOVE, 6'd0,  32'h0);
      send_op(plk_pkg::MODE_REMOVE, 6'd2,  32'h0);
      send_op(plk_pkg::MODE_READ,   6'd0,  32'h0);
      send_op(plk_pkg::MODE_READ,   6'd2,  32'h0);
   endtask

   // Zero capacity, capacity lowered below the count, single-entry capacity
   task automatic test_capacity_edges();
      write_capacity(0);
      send_op(plk_pkg::MODE_INSERT, 6'd0, 32'hdead_beef);
      write_capacity(1);
      send_op(plk_pkg::MODE_INSERT, 6'd0, 32'h0bad_cafe);
      send_op(plk_pkg::MODE_REMOVE, 6'd0, 32'h0);
      send_op(plk_pkg::MODE_INSERT, 6'd1, 32'h0bad_cafe);
      send_op(plk_pkg::MODE_REMOVE, 6'd63, 32'h0);
      send_op(plk_pkg::MODE_INSERT, 6'd9, 32'hcafe_f00d);
      send_op(plk_pkg::MODE_INSERT, 6'd0, 32'h0000_0002);
      send_op(plk_pkg::MODE_READ,   6'd0, 32'h0);
   endtask

   // Random operations steered between filling and draining the list
   task automatic test_random_mix(input int items, input int cap, input int idle_pct);
      bit         filling;
      int         room;
      int         roll;
      logic [1:0] heavy;
      logic [1:0] light;
      logic [1:0] mode;
      filling = 1'b1;
      write_capacity(cap);
      sender_idle_pct = idle_pct;
      room = (cap > LIST_DEPTH) ? LIST_DEPTH : cap;
      for (int k = 0; k < items; k++) begin
         // hold off once mid-phase until the block has answered everything
         if (k == items / 2) wait_drained();
         // flip the trend a little after reaching full or empty
         if (filling && list_count >= room && $urandom_range(3) == 0) filling = 1'b0;
         if (!filling && list_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
         heavy = filling ? plk_pkg::MODE_INSERT : plk_pkg::MODE_REMOVE;
         light = filling ? plk_pkg::MODE_REMOVE : plk_pkg::MODE_INSERT;
         roll = $urandom_range(99);
         if (roll < 64)      mode = heavy;
         else if (roll < 76) mode = light;
         else if (roll < 88) mode = plk_pkg::MODE_READ;
         else                mode = plk_pkg::MODE_MODIFY;
         send_op(mode, pick_position(), pick_value());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_capacity_edges();
      test_random_mix(200, LIST_DEPTH, 31);
      test_random_mix(150, 127, 31);
      test_random_mix(100, (list_count > 1) ? list_count / 2 : 1, 70);
      test_random_mix(80, 1, 70);
      test_random_mix(40, 0, 0);
      test_random_mix(130, plk_pkg::CAPACITY_RESET, 0);

      // Let any late or stray response show up before judging
      wait_drained();
      repeat (LATENCY_MAX + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
